FILE: sv/ppc_pkg.sv
`default_nettype none
package ppc_pkg;

	localparam int RULES   = 64;
	localparam int FIELDS  = 5;
	localparam int RULE_AW = $clog2(RULES);
	localparam int RCNT_W  = $clog2(RULES + 1);
	localparam int FLD_W   = 32;
	localparam int PLEN_W  = 6;
	localparam int PRI_W   = 16;
	localparam int ACT_W   = 32;
	localparam int FCNT_W  = 3;
	localparam int CFG_W   = 7;

	localparam logic [FLD_W-1:0] MASK_ALL = 32'hffffffff;
	localparam logic [FLD_W-1:0] MASK_TOP = 32'h80000000;

	localparam logic [1:0] OP_KEY   = 2'd0;
	localparam logic [1:0] OP_ACT   = 2'd1;
	localparam logic [1:0] OP_CLASS = 2'd2;

	localparam logic REG_FIELD_COUNT = 1'b0;
	localparam logic REG_RULE_COUNT  = 1'b1;

	typedef struct packed {
		logic wr_key;
		logic wr_act;
		logic load;
		logic rd;
	} ppc_cmd_t;

	typedef struct packed {
		logic empty;
		logic last;
	} ppc_sts_t;

	// top len bits set; len of 32 or more sets all
	function automatic logic [FLD_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
		logic [FLD_W-1:0] m;
		if (len == '0) begin
			m = '0;
		end else if (len >= PLEN_W'(FLD_W)) begin
			m = MASK_ALL;
		end else begin
			m = MASK_TOP | ~(MASK_ALL >> len);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

FILE: sv/ppc_ctrl.sv
`default_nettype none
module ppc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [1:0]        opcode,
	input  wire ppc_pkg::ppc_sts_t sts,
	output ppc_pkg::ppc_cmd_t      cmd,
	output logic                   busy,
	output logic                   done
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   take;

	assign take = start && (state_q == ST_IDLE);

	always_comb begin
		cmd.wr_key = take && (opcode == ppc_pkg::OP_KEY);
		cmd.wr_act = take && (opcode == ppc_pkg::OP_ACT);
		cmd.load   = take && (opcode == ppc_pkg::OP_CLASS);
		cmd.rd     = (state_q == ST_READ);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_d = sts.empty ? ST_DONE : ST_READ;
				end
			end
			ST_READ: begin
				if (sts.last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule
`default_nettype wire

FILE: sv/ppc_dpath.sv
`default_nettype none
module ppc_dpath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ppc_pkg::ppc_cmd_t            cmd,
	output ppc_pkg::ppc_sts_t                 sts,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [ppc_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic [5:0]                   rule_index,
	input  wire logic [2:0]                   field_index,
	input  wire logic [ppc_pkg::FLD_W-1:0]    key_value,
	input  wire logic [ppc_pkg::PLEN_W-1:0]   key_len,
	input  wire logic [ppc_pkg::PRI_W-1:0]    priority_req,
	input  wire logic [ppc_pkg::ACT_W-1:0]    action,
	input  wire logic [ppc_pkg::FLD_W-1:0]    pkt [ppc_pkg::FIELDS],
	output logic [ppc_pkg::ACT_W-1:0]         result_action,
	output logic                              matched,
	output logic [5:0]                        winner_index
);

	localparam int ENT_W = ppc_pkg::FLD_W + ppc_pkg::PLEN_W;
	localparam int RA_W  = ppc_pkg::PRI_W + ppc_pkg::ACT_W;

	logic [ppc_pkg::FCNT_W-1:0]  field_count_q;
	logic [ppc_pkg::CFG_W-1:0]   rule_count_q;
	logic [ppc_pkg::FCNT_W-1:0]  nf_q;
	logic [ppc_pkg::RCNT_W-1:0]  nr_q;
	logic [ppc_pkg::RCNT_W-1:0]  nr_eff;
	logic [ppc_pkg::RULE_AW-1:0] addr_q;
	logic [ppc_pkg::FLD_W-1:0]   pkt_q [ppc_pkg::FIELDS];

	logic [ENT_W-1:0]            ent_s1 [ppc_pkg::FIELDS];
	logic [RA_W-1:0]             ra_s1;
	logic                        vld_s1;
	logic [ppc_pkg::RULE_AW-1:0] idx_s1;

	logic                        hit_q;
	logic [ppc_pkg::PRI_W-1:0]   best_pri_q;
	logic [ppc_pkg::ACT_W-1:0]   best_act_q;
	logic [ppc_pkg::RULE_AW-1:0] best_idx_q;

	logic [ppc_pkg::FIELDS-1:0]  fld_ok;
	logic                        rule_ok;
	logic                        ri_ok;
	logic [ppc_pkg::PRI_W-1:0]   rd_pri;
	logic [ppc_pkg::ACT_W-1:0]   rd_act;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_count_q <= ppc_pkg::FCNT_W'(5);
			rule_count_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ppc_pkg::REG_FIELD_COUNT: field_count_q <= cfg_data[ppc_pkg::FCNT_W-1:0];
				ppc_pkg::REG_RULE_COUNT:  rule_count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign nr_eff = (32'(rule_count_q) > ppc_pkg::RULES) ? ppc_pkg::RCNT_W'(ppc_pkg::RULES)
	                                                     : ppc_pkg::RCNT_W'(rule_count_q);
	assign ri_ok  = (32'(rule_index) < ppc_pkg::RULES);

	assign sts.empty = (nr_eff == '0);
	assign sts.last  = (ppc_pkg::RCNT_W'(addr_q) == (nr_q - ppc_pkg::RCNT_W'(1)));

	// per-field rule memories, one word = key and prefix length
	for (genvar f = 0; f < ppc_pkg::FIELDS; f++) begin : g_fld
		logic [ENT_W-1:0] mem [ppc_pkg::RULES];

		always_ff @(posedge clk) begin
			if (cmd.wr_key && ri_ok && (field_index == 3'(f))) begin
				mem[rule_index[ppc_pkg::RULE_AW-1:0]] <= {key_value, key_len};
			end
			if (cmd.rd) begin
				ent_s1[f] <= mem[addr_q];
			end
		end

		assign fld_ok[f] = (3'(f) >= nf_q) ||
			((pkt_q[f] & ppc_pkg::prefix_mask(ent_s1[f][ppc_pkg::PLEN_W-1:0])) ==
			 ent_s1[f][ENT_W-1:ppc_pkg::PLEN_W]);
	end

	logic [RA_W-1:0] ra_mem [ppc_pkg::RULES];

	always_ff @(posedge clk) begin
		if (cmd.wr_act && ri_ok) begin
			ra_mem[rule_index[ppc_pkg::RULE_AW-1:0]] <= {priority_req, action};
		end
		if (cmd.rd) begin
			ra_s1  <= ra_mem[addr_q];
			idx_s1 <= addr_q;
		end
	end

	assign rd_pri  = ra_s1[RA_W-1:ppc_pkg::ACT_W];
	assign rd_act  = ra_s1[ppc_pkg::ACT_W-1:0];
	assign rule_ok = &fld_ok;

	// packet latch and read address
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pkt_q <= pkt;
			nf_q  <= (32'(field_count_q) > ppc_pkg::FIELDS) ? ppc_pkg::FCNT_W'(ppc_pkg::FIELDS)
			                                                : field_count_q;
			nr_q  <= nr_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			vld_s1 <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd;
			if (cmd.load) begin
				addr_q <= '0;
				hit_q  <= 1'b0;
			end else begin
				if (cmd.rd) begin
					addr_q <= addr_q + ppc_pkg::RULE_AW'(1);
				end
				if (vld_s1 && rule_ok && (!hit_q || (rd_pri >= best_pri_q))) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// running best; ties go to the later rule
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			best_pri_q <= '0;
			best_act_q <= '0;
			best_idx_q <= '0;
		end else if (vld_s1 && rule_ok && (!hit_q || (rd_pri >= best_pri_q))) begin
			best_pri_q <= rd_pri;
			best_act_q <= rd_act;
			best_idx_q <= idx_s1;
		end
	end

	assign result_action = best_act_q;
	assign matched       = hit_q;
	assign winner_index  = 6'(best_idx_q);

endmodule
`default_nettype wire

FILE: sv/priority_prefix_packet_classifier.sv
// Classify: once start is taken, n = min(rule_count,64) stored rules are read, one per cycle,
// then a flush state passes and done strobes; with no rule in use done strobes in the cycle after start is taken.
// The next word is taken in the cycle after done.
// Rule writes give no result and keep busy low; receiver cannot stall.
// arst_n clears the controller and sets field_count 5, rule_count 0;
// rule memories are not cleared and hold nothing defined until written.
`default_nettype none
module priority_prefix_packet_classifier (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [1:0]                 opcode,
	input  wire logic [5:0]                 rule_index,
	input  wire logic [2:0]                 field_index,
	input  wire logic [31:0]                key_value,
	input  wire logic [5:0]                 key_len,
	input  wire logic [15:0]                priority_req,
	input  wire logic [31:0]                action,
	input  wire logic [31:0]                pkt_field_0,
	input  wire logic [31:0]                pkt_field_1,
	input  wire logic [31:0]                pkt_field_2,
	input  wire logic [31:0]                pkt_field_3,
	input  wire logic [31:0]                pkt_field_4,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic                       cfg_index,
	input  wire logic [ppc_pkg::CFG_W-1:0]  cfg_data,
	output logic                            done,
	output logic [31:0]                     result_action,
	output logic                            matched,
	output logic [5:0]                      winner_index
);

	ppc_pkg::ppc_cmd_t cmd;
	ppc_pkg::ppc_sts_t sts;
	logic [ppc_pkg::FLD_W-1:0] pkt [ppc_pkg::FIELDS];

	assign cfg_ready = 1'b1;
	assign pkt = '{pkt_field_0, pkt_field_1, pkt_field_2, pkt_field_3, pkt_field_4};

	ppc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ppc_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rule_index    (rule_index),
		.field_index   (field_index),
		.key_value     (key_value),
		.key_len       (key_len),
		.priority_req  (priority_req),
		.action        (action),
		.pkt           (pkt),
		.result_action (result_action),
		.matched       (matched),
		.winner_index  (winner_index)
	);

endmodule
`default_nettype wire
